### src/u2u_pkg.sv
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types, byte-class constants and lead-byte classification for the
// UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

	localparam int unsigned MAX_RES = 3;

	localparam logic [15:0] REPL_RESET = 16'h003F;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_MASK  = 8'hE0;
	localparam logic [7:0] LEAD2_VAL   = 8'hC0;
	localparam logic [7:0] LEAD3_MASK  = 8'hF0;
	localparam logic [7:0] LEAD3_VAL   = 8'hE0;
	localparam logic [7:0] LEAD4_MASK  = 8'hF8;
	localparam logic [7:0] LEAD4_VAL   = 8'hF0;
	localparam logic [7:0] LEAD5_MASK  = 8'hFC;
	localparam logic [7:0] LEAD5_VAL   = 8'hF8;
	localparam logic [7:0] LEAD6_MASK  = 8'hFE;
	localparam logic [7:0] LEAD6_VAL   = 8'hFC;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_VAL    = 8'h80;

	localparam logic [1:0] LEN_TWO   = 2'd2;
	localparam logic [1:0] LEN_THREE = 2'd3;

	localparam logic [2:0] SKIP_LEAD4 = 3'd3;
	localparam logic [2:0] SKIP_LEAD5 = 3'd4;
	localparam logic [2:0] SKIP_LEAD6 = 3'd5;

	typedef struct packed {
		logic [1:0] pend;
		logic [1:0] exp_len;
		logic [7:0] lead;
		logic [7:0] mid;
		logic [2:0] skip;
	} dec_state_t;

	typedef struct packed {
		logic [15:0] code;
		logic        rep;
	} res_t;

	typedef struct packed {
		logic       emit;
		logic       rep;
		logic       hold;
		logic [1:0] exp_len;
		logic [2:0] skip;
	} fresh_t;

	function automatic fresh_t fresh_decode(input logic [7:0] b);
		fresh_t f;
		f = '0;
		if (b < ASCII_LIMIT) begin
			f.emit = (b != 8'h00);
		end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
			f.hold    = 1'b1;
			f.exp_len = LEN_TWO;
		end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
			f.hold    = 1'b1;
			f.exp_len = LEN_THREE;
		end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
			f.emit = 1'b1;
			f.rep  = 1'b1;
			f.skip = SKIP_LEAD4;
		end else if ((b & LEAD5_MASK) == LEAD5_VAL) begin
			f.emit = 1'b1;
			f.rep  = 1'b1;
			f.skip = SKIP_LEAD5;
		end else if ((b & LEAD6_MASK) == LEAD6_VAL) begin
			f.emit = 1'b1;
			f.rep  = 1'b1;
			f.skip = SKIP_LEAD6;
		end else begin
			f.emit = 1'b1;
			f.rep  = 1'b1;
		end
		return f;
	endfunction

endpackage

### src/utf8_to_ucs2_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder
// Streaming UTF-8 to UCS-2 decoder with a programmable replacement code.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the in channel (in_valid/in_ready) with end_of_string
//   marking the last byte of a string. Code units leave on the out channel
//   (out_valid/out_ready); last_of_run flags the final code unit caused by
//   one input byte. The replacement code is written on the cfg channel,
//   which is always ready; the user must write it only while the decoder
//   is idle, as the block does not enforce this. Each accepted byte is
//   decoded in the cycle it is taken and its burst of zero to three code
//   units lands in a three-entry result register, so the first code unit
//   appears in the cycle after acceptance. A byte that gives zero or one
//   code unit frees the result register in the cycle it drains, so with
//   out_ready held high one byte is taken every cycle. A longer burst
//   stalls input as it drains, a code unit each cycle out_ready is high.
//   When the receiver stalls, the current code unit holds and in_ready drops
//   once the result register is occupied.
//   Reset clears the held sequence, skip count and result count, so the
//   result register is empty, and sets the replacement code to 0x003F.
// ----------------------------------------------------------------------------
module utf8_to_ucs2_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        end_of_string,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] code_unit,
	output logic        is_replacement,
	output logic        last_of_run
);

	u2u_pkg::dec_state_t st_q;
	u2u_pkg::dec_state_t st_nxt;
	u2u_pkg::res_t       res [u2u_pkg::MAX_RES];
	u2u_pkg::res_t       ent_s1 [u2u_pkg::MAX_RES];
	logic [1:0]          res_cnt;
	logic [1:0]          rem_q;
	logic [15:0]         repl_q;
	logic                in_acc;
	logic                out_acc;

	u2u_decode u_dec (
		.st            (st_q),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.repl          (repl_q),
		.st_nxt        (st_nxt),
		.res           (res),
		.res_cnt       (res_cnt)
	);

	assign cfg_ready      = 1'b1;
	assign out_valid      = rem_q != 2'd0;
	assign out_acc        = out_valid && out_ready;
	assign in_ready       = (rem_q == 2'd0) || (rem_q == 2'd1 && out_ready);
	assign in_acc         = in_valid && in_ready;
	assign code_unit      = ent_s1[0].code;
	assign is_replacement = ent_s1[0].rep;
	assign last_of_run    = rem_q == 2'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= u2u_pkg::REPL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			repl_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= '0;
			rem_q <= 2'd0;
		end else if (in_acc) begin
			st_q  <= st_nxt;
			rem_q <= res_cnt;
		end else if (out_acc) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	// load a new burst, or advance the current one
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < u2u_pkg::MAX_RES; i++) begin
				ent_s1[i] <= res[i];
			end
		end else if (out_acc) begin
			ent_s1[0] <= ent_s1[1];
			ent_s1[1] <= ent_s1[2];
		end
	end

	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && rem_q != 2'd0) |-> (out_ready && last_of_run))
		else $error("input taken while a burst is still pending");

	a_burst_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |=> out_valid)
		else $error("gap inside a result burst");

	a_skip_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.skip != 3'd0) |-> (st_q.pend == 2'd0))
		else $error("skip active with a held sequence");

	a_mid_three: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.pend == 2'd2) |-> (st_q.exp_len == u2u_pkg::LEN_THREE))
		else $error("middle byte held for a two-byte sequence");

endmodule

### src/u2u_decode.sv
// ----------------------------------------------------------------------------
// u2u_decode
// Combinational decode of one byte against the held sequence state: next
// state and the burst of up to three code units the byte causes.
// ----------------------------------------------------------------------------
module u2u_decode (
	input  u2u_pkg::dec_state_t st,
	input  logic [7:0]          in_byte,
	input  logic                end_of_string,
	input  logic [15:0]         repl,
	output u2u_pkg::dec_state_t st_nxt,
	output u2u_pkg::res_t       res [u2u_pkg::MAX_RES],
	output logic [1:0]          res_cnt
);

	u2u_pkg::fresh_t fr;
	u2u_pkg::res_t   rep_res;
	u2u_pkg::res_t   fr_res;
	logic            is_cont;
	logic            done;
	logic            had_mid;
	logic [15:0]     code;

	assign fr      = u2u_pkg::fresh_decode(in_byte);
	assign rep_res = '{code: repl, rep: 1'b1};
	assign fr_res  = fr.rep ? rep_res : u2u_pkg::res_t'{code: {8'h00, in_byte}, rep: 1'b0};
	assign is_cont = (in_byte & u2u_pkg::CONT_MASK) == u2u_pkg::CONT_VAL;
	assign done    = ({1'b0, st.pend} + 3'd1) >= {1'b0, st.exp_len};
	assign had_mid = st.pend >= 2'd2;
	assign code    = (st.exp_len == u2u_pkg::LEN_THREE) ?
		{st.lead[3:0], st.mid[5:0], in_byte[5:0]} :
		{5'b00000, st.lead[4:0], in_byte[5:0]};

	always_comb begin
		st_nxt  = st;
		res_cnt = 2'd0;
		for (int i = 0; i < u2u_pkg::MAX_RES; i++) begin
			res[i] = '0;
		end
		if (st.skip != 3'd0) begin
			st_nxt.skip = st.skip - 3'd1;
		end else if (st.pend == 2'd0) begin
			if (fr.emit) begin
				res[0]  = fr_res;
				res_cnt = 2'd1;
			end
			if (fr.hold) begin
				st_nxt.lead    = in_byte;
				st_nxt.pend    = 2'd1;
				st_nxt.exp_len = fr.exp_len;
			end
			st_nxt.skip = fr.skip;
		end else if (is_cont) begin
			if (done) begin
				st_nxt.pend    = 2'd0;
				st_nxt.exp_len = 2'd0;
				st_nxt.lead    = 8'h00;
				st_nxt.mid     = 8'h00;
				if (code != 16'h0000) begin
					res[0]  = '{code: code, rep: 1'b0};
					res_cnt = 2'd1;
				end
			end else begin
				st_nxt.mid  = in_byte;
				st_nxt.pend = 2'd2;
			end
		end else begin
			st_nxt.pend    = 2'd0;
			st_nxt.exp_len = 2'd0;
			st_nxt.lead    = 8'h00;
			st_nxt.mid     = 8'h00;
			res[0]  = rep_res;
			res_cnt = 2'd1;
			if (had_mid) begin
				res[1]  = rep_res;
				res_cnt = 2'd2;
			end
			if (fr.emit) begin
				res[res_cnt] = fr_res;
				res_cnt      = res_cnt + 2'd1;
			end
			if (fr.hold) begin
				st_nxt.lead    = in_byte;
				st_nxt.pend    = 2'd1;
				st_nxt.exp_len = fr.exp_len;
			end
			st_nxt.skip = fr.skip;
		end

		if (end_of_string) begin
			if (st_nxt.pend != 2'd0 && res_cnt != 2'd3) begin
				res[res_cnt] = rep_res;
				res_cnt      = res_cnt + 2'd1;
			end
			if (st_nxt.pend == 2'd2 && res_cnt != 2'd3) begin
				res[res_cnt] = rep_res;
				res_cnt      = res_cnt + 2'd1;
			end
			st_nxt = '0;
		end
	end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the UTF-8 to UCS-2 stream decoder. Directed tests
// cover ASCII, stray bytes, two- and three-byte sequences, long leads and
// their skipped bytes, bad continuations and end-of-string flushing. Random
// strings follow, under several replacement codes. A built-in decoder
// predicts every code unit, and a checker compares each output transaction
// with the oldest prediction. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef struct {
		logic [15:0] code;
		logic        rep;
		logic        is_last;
	} unit_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        end_of_string;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] code_unit;
	logic        is_replacement;
	logic        last_of_run;

	unit_t       ucs2_q[$];
	int unsigned mismatch_cnt;
	int unsigned cycle_cnt;
	int unsigned bytes_sent;
	int unsigned rx_hold;
	bit          tx_steady;
	bit          rx_steady;

	logic [1:0]  held_cnt;
	logic [1:0]  seq_len;
	logic [7:0]  lead_b;
	logic [7:0]  mid_b;
	logic [2:0]  skip_cnt;
	logic [15:0] repl_code;

	utf8_to_ucs2_stream_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.code_unit     (code_unit),
		.is_replacement(is_replacement),
		.last_of_run   (last_of_run)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 92)
			return $urandom_range(3, 6);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic void add_unit(ref unit_t burst[$], input logic [15:0] code,
			input logic rep);
		unit_t u;
		u.code    = code;
		u.rep     = rep;
		u.is_last = 1'b0;
		if (burst.size() < u2u_pkg::MAX_RES)
			burst.push_back(u);
	endfunction

	function automatic void drop_held();
		held_cnt = '0;
		seq_len  = '0;
		lead_b   = '0;
		mid_b    = '0;
	endfunction

	function automatic void start_sequence(ref unit_t burst[$], input logic [7:0] b);
		if (b < u2u_pkg::ASCII_LIMIT) begin
			if (b != 8'h00)
				add_unit(burst, {8'h00, b}, 1'b0);
		end else if ((b & u2u_pkg::LEAD2_MASK) == u2u_pkg::LEAD2_VAL) begin
			lead_b   = b;
			held_cnt = 2'd1;
			seq_len  = u2u_pkg::LEN_TWO;
		end else if ((b & u2u_pkg::LEAD3_MASK) == u2u_pkg::LEAD3_VAL) begin
			lead_b   = b;
			held_cnt = 2'd1;
			seq_len  = u2u_pkg::LEN_THREE;
		end else if ((b & u2u_pkg::LEAD4_MASK) == u2u_pkg::LEAD4_VAL) begin
			add_unit(burst, repl_code, 1'b1);
			skip_cnt = u2u_pkg::SKIP_LEAD4;
		end else if ((b & u2u_pkg::LEAD5_MASK) == u2u_pkg::LEAD5_VAL) begin
			add_unit(burst, repl_code, 1'b1);
			skip_cnt = u2u_pkg::SKIP_LEAD5;
		end else if ((b & u2u_pkg::LEAD6_MASK) == u2u_pkg::LEAD6_VAL) begin
			add_unit(burst, repl_code, 1'b1);
			skip_cnt = u2u_pkg::SKIP_LEAD6;
		end else begin
			add_unit(burst, repl_code, 1'b1);
		end
	endfunction

	function automatic void decode_utf8_byte(input logic [7:0] b, input logic eos);
		unit_t       burst[$];
		logic        had_mid;
		logic [15:0] cu;
		if (skip_cnt != 0) begin
			skip_cnt = skip_cnt - 3'd1;
		end else if (held_cnt == 0) begin
			start_sequence(burst, b);
		end else if ((b & u2u_pkg::CONT_MASK) == u2u_pkg::CONT_VAL) begin
			if (held_cnt + 1 >= seq_len) begin
				if (seq_len == u2u_pkg::LEN_THREE)
					cu = {lead_b[3:0], mid_b[5:0], b[5:0]};
				else
					cu = {5'b0, lead_b[4:0], b[5:0]};
				drop_held();
				if (cu != 16'h0000)
					add_unit(burst, cu, 1'b0);
			end else begin
				mid_b    = b;
				held_cnt = 2'd2;
			end
		end else begin
			had_mid = (held_cnt >= 2);
			drop_held();
			add_unit(burst, repl_code, 1'b1);
			if (had_mid)
				add_unit(burst, repl_code, 1'b1);
			start_sequence(burst, b);
		end
		if (eos) begin
			repeat (held_cnt) add_unit(burst, repl_code, 1'b1);
			drop_held();
			skip_cnt = '0;
		end
		if (burst.size() > 0)
			burst[burst.size() - 1].is_last = 1'b1;
		foreach (burst[i])
			ucs2_q.push_back(burst[i]);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eos);
		in_byte       = b;
		end_of_string = eos;
		in_valid      = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decode_utf8_byte(b, eos);
		bytes_sent++;
		@(negedge clk);
		in_valid = 1'b0;
		if (!tx_steady && $urandom_range(0, 2) == 0)
			repeat (pick_gap()) @(negedge clk);
	endtask

	task automatic wait_idle();
		while (ucs2_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_repl(input logic [15:0] value);
		wait_idle();
		cfg_data  = value;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		repl_code = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_string(input int unsigned nchars, input bit truncate);
		logic [7:0]  seq[$];
		logic [7:0]  nb;
		int unsigned r;
		int unsigned nskip;
		for (int unsigned c = 0; c < nchars; c++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				seq.push_back(8'($urandom_range(0, 127)));
			end else if (r < 55) begin
				seq.push_back({3'b110, 5'($urandom)});
				seq.push_back({2'b10, 6'($urandom)});
			end else if (r < 75) begin
				seq.push_back({4'b1110, 4'($urandom)});
				seq.push_back({2'b10, 6'($urandom)});
				seq.push_back({2'b10, 6'($urandom)});
			end else if (r < 80) begin
				nb = 8'($urandom_range(8'hF0, 8'hFD));
				seq.push_back(nb);
				nskip = (nb < 8'hF8) ? 3 : (nb < 8'hFC) ? 4 : 5;
				repeat (nskip) seq.push_back(8'($urandom_range(0, 255)));
			end else if (r < 92) begin
				if ($urandom_range(0, 1)) begin
					seq.push_back({3'b110, 5'($urandom)});
				end else begin
					seq.push_back({4'b1110, 4'($urandom)});
					if ($urandom_range(0, 1))
						seq.push_back({2'b10, 6'($urandom)});
				end
				nb = 8'($urandom_range(0, 255));
				if (nb[7:6] == 2'b10)
					nb[6] = 1'b1;
				seq.push_back(nb);
			end else begin
				seq.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (truncate && seq.size() > 2)
			repeat ($urandom_range(1, 2)) void'(seq.pop_back());
		foreach (seq[i])
			send_byte(seq[i], i == seq.size() - 1);
	endtask

	task automatic test_reset_value();
		send_byte(8'h41, 1'b0);
		send_byte(8'h80, 1'b0);
	endtask

	task automatic test_ascii_and_zero();
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b0);
	endtask

	task automatic test_stray_bytes();
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hBF, 1'b0);
	endtask

	task automatic test_two_byte();
		send_byte(8'hC3, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hC0, 1'b0);
		send_byte(8'h80, 1'b0);
	endtask

	task automatic test_three_byte();
		send_byte(8'hED, 1'b0);
		send_byte(8'hA0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBF, 1'b0);
	endtask

	task automatic test_long_leads();
		send_byte(8'hF8, 1'b0);
		repeat (4) send_byte(8'h41, 1'b0);
		send_byte(8'hFC, 1'b0);
		send_byte(8'hC3, 1'b1);
		send_byte(8'h42, 1'b0);
	endtask

	task automatic test_bad_continuation();
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'h41, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hC3, 1'b1);
	endtask

	task automatic test_end_of_string();
		send_byte(8'hC3, 1'b1);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b1);
	endtask

	task automatic test_replacement_code();
		write_repl(16'h0000);
		send_byte(8'hFF, 1'b0);
		write_repl(16'hFFFF);
		send_byte(8'h80, 1'b1);
	endtask

	task automatic test_random_strings();
		logic [15:0] codes[5];
		int unsigned phase_end;
		codes = '{16'($urandom), 16'h0000, 16'hFFFF, 16'($urandom), u2u_pkg::REPL_RESET};
		for (int p = 0; p < 5; p++) begin
			write_repl(codes[p]);
			tx_steady = (p == 2);
			rx_steady = (p == 2);
			phase_end = bytes_sent + 34;
			while (bytes_sent < phase_end) begin
				send_string($urandom_range(1, 10), $urandom_range(0, 4) == 0);
				if ($urandom_range(0, 7) == 0)
					wait_idle();
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		in_byte       = '0;
		end_of_string = 1'b0;
		mismatch_cnt  = 0;
		bytes_sent    = 0;
		tx_steady     = 1'b0;
		rx_steady     = 1'b0;
		repl_code     = u2u_pkg::REPL_RESET;
		skip_cnt      = '0;
		drop_held();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_value();
		test_ascii_and_zero();
		test_stray_bytes();
		test_two_byte();
		test_three_byte();
		test_long_leads();
		test_bad_continuation();
		test_end_of_string();
		test_replacement_code();
		test_random_strings();

		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		rx_hold   = 0;
	end

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready = 1'b0;
			rx_hold--;
		end else begin
			out_ready = 1'b1;
			if (!rx_steady && $urandom_range(0, 3) == 0)
				rx_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		unit_t u;
		if (arst_n && out_valid && out_ready) begin
			if (ucs2_q.size() == 0) begin
				$error("code_unit %h arrived with no expected transaction", code_unit);
				mismatch_cnt++;
			end else begin
				u = ucs2_q.pop_front();
				if (code_unit !== u.code) begin
					$error("code_unit: expected %h, actual %h", u.code, code_unit);
					mismatch_cnt++;
				end
				if (is_replacement !== u.rep) begin
					$error("is_replacement: expected %b, actual %b", u.rep, is_replacement);
					mismatch_cnt++;
				end
				if (last_of_run !== u.is_last) begin
					$error("last_of_run: expected %b, actual %b", u.is_last, last_of_run);
					mismatch_cnt++;
				end
			end
		end
	end

	initial cycle_cnt = 0;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule
